[hw/rtl/folt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// folt_pkg: shared definitions of the frequency ordered lookup table
// action and status codes, field widths and the command bundle for the cells
// ----------------------------------------------------------------------------
package folt_pkg;

  // word field widths
  localparam int ACT_W  = 2;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int FREQ_W = 16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic             find;    // latch the first-match flag
    logic             move;    // apply the shift and insert of a hit
    logic             append;  // write a new entry at the fill point
    logic [KEY_W-1:0] key;     // key compared, inserted or appended
  } cmd_t;

endpackage

[hw/rtl/folt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// folt_cell: one table entry
// holds a key and its count, takes part in the first-match and insert chains
// ----------------------------------------------------------------------------
module folt_cell import folt_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [COUNT_BITS-1:0] new_cnt,
  input  logic                  used,
  input  logic                  app_here,
  input  logic [KEY_W-1:0]      prev_key,
  input  logic [COUNT_BITS-1:0] prev_cnt,
  input  logic                  found_in,
  output logic                  found_out,
  input  logic                  passed_in,
  output logic                  passed_out,
  input  logic                  taken_in,
  output logic                  taken_out,
  output logic                  hit_now,
  output logic                  is_dest,
  output logic [KEY_W-1:0]      key_q,
  output logic [COUNT_BITS-1:0] cnt_q
);

  logic [KEY_W-1:0]      key_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  hit_r;
  logic                  match;
  logic                  at_or_before_hit;
  logic                  sel;
  logic                  shift;

  // first-match chain
  assign match     = used && (key_r == cmd.key);
  assign hit_now   = match && !found_in;
  assign found_out = found_in || match;

  // insert chain: first cell up to the hit whose count falls below the new one
  assign passed_out       = passed_in || hit_r;
  assign at_or_before_hit = !passed_in;
  assign sel              = at_or_before_hit && (hit_r || (cnt_r < new_cnt));
  assign is_dest          = sel && !taken_in;
  assign taken_out        = taken_in || sel;
  assign shift            = taken_in && at_or_before_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.find) begin
      hit_r <= hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move && is_dest) begin
      key_r <= cmd.key;
      cnt_r <= new_cnt;
    end else if (cmd.move && shift) begin
      key_r <= prev_key;
      cnt_r <= prev_cnt;
    end else if (cmd.append && app_here) begin
      key_r <= cmd.key;
      cnt_r <= '0;
    end
  end

  assign key_q = key_r;
  assign cnt_q = cnt_r;

endmodule

[hw/rtl/frequency_ordered_lookup_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_ordered_lookup_table_top: self-organizing table ordered by count
// a row of entry cells kept in descending access-count order
// ----------------------------------------------------------------------------
// usage
//   input words carry an action (clear, append, look up) and a 32-bit key;
//   every input word yields exactly one result word with status, position
//   and frequency, in order
//   an input word is taken in the cycle that in_tvalid and in_tready are high;
//   in that same cycle all cells compare the key in parallel along the
//   first-match chain and the hit count is latched
//   the commit follows once the output register is free: for a look-up hit the
//   insert chain finds the new place, the cells between it and the hit shift
//   back by one, and the result is loaded into the output register
//   so an item passes the compare step and then the shift step of the cell row;
//   no new word is taken until it commits, and the result shows on out_tvalid once committed
//   when the receiver stalls the result waits in the output register while
//   one more word is accepted; the commit of that word then waits for the slot
//   reset empties the table (fill count zero) and drops any pending result
// ----------------------------------------------------------------------------
module frequency_ordered_lookup_table_top import folt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[1:0], key[33:2], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[1:0], position[5:2], frequency[21:6], zero fill
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int TOT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic                  state_r, state_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;
  logic [ACT_W-1:0]      act_r;
  logic [KEY_W-1:0]      key_r;
  logic                  found_r;
  logic [COUNT_BITS-1:0] new_cnt_r;
  logic                  out_valid_r;
  logic [23:0]           out_data_r, out_data_nxt;

  logic                  accept;
  logic                  fire;
  logic                  has_room;
  cmd_t                  cmd;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [IDX_W-1:0]      dest_idx;

  // chains across the row; the entry past the end marks the row result
  logic [TABLE_DEPTH:0]   found_c;
  logic [TABLE_DEPTH:0]   passed_c;
  logic [TABLE_DEPTH:0]   taken_c;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] dest_vec;
  logic [KEY_W-1:0]       key_q   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]  cnt_q   [TABLE_DEPTH];

  assign accept    = in_tvalid && in_tready;
  // no word is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign fire      = (state_r == S_COMMIT) && (!out_valid_r || out_tready);
  assign has_room  = (total_r < TOT_W'(TABLE_DEPTH));

  // cells compare against the incoming key while idle, the held key otherwise
  always_comb begin
    cmd.find   = accept;
    cmd.move   = fire && (act_r == ACT_LOOKUP) && found_r;
    cmd.append = fire && (act_r == ACT_APPEND) && has_room;
    cmd.key    = (state_r == S_IDLE) ? in_tdata[33:2] : key_r;
  end

  assign found_c[0]  = 1'b0;
  assign passed_c[0] = 1'b0;
  assign taken_c[0]  = 1'b0;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    logic [KEY_W-1:0]      pk;
    logic [COUNT_BITS-1:0] pc;

    if (j == 0) begin : g_head
      assign pk = '0;
      assign pc = '0;
    end else begin : g_body
      assign pk = key_q[j-1];
      assign pc = cnt_q[j-1];
    end

    folt_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_cnt    (new_cnt_r),
      .used       (TOT_W'(j) < total_r),
      .app_here   (TOT_W'(j) == total_r),
      .prev_key   (pk),
      .prev_cnt   (pc),
      .found_in   (found_c[j]),
      .found_out  (found_c[j+1]),
      .passed_in  (passed_c[j]),
      .passed_out (passed_c[j+1]),
      .taken_in   (taken_c[j]),
      .taken_out  (taken_c[j+1]),
      .hit_now    (hit_vec[j]),
      .is_dest    (dest_vec[j]),
      .key_q      (key_q[j]),
      .cnt_q      (cnt_q[j])
    );
  end

  // one-hot selects: count of the matching cell, index of the insert place
  always_comb begin
    hit_cnt  = '0;
    dest_idx = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (hit_vec[j]) begin
        hit_cnt = hit_cnt | cnt_q[j];
      end
      if (dest_vec[j]) begin
        dest_idx = dest_idx | IDX_W'(j);
      end
    end
  end

  // result word for the item being committed
  always_comb begin
    out_data_nxt = '0;
    unique case (act_r)
      ACT_LOOKUP: begin
        if (found_r) begin
          out_data_nxt[1:0]  = ST_OK;
          out_data_nxt[5:2]  = POS_W'(dest_idx);
          out_data_nxt[21:6] = FREQ_W'(new_cnt_r);
        end else begin
          out_data_nxt[1:0]  = ST_MISS;
        end
      end
      ACT_APPEND: begin
        if (has_room) begin
          out_data_nxt[1:0] = ST_OK;
          out_data_nxt[5:2] = POS_W'(total_r);
        end else begin
          out_data_nxt[1:0] = ST_FULL;
        end
      end
      default: begin
        out_data_nxt[1:0] = ST_OK;
      end
    endcase
  end

  always_comb begin
    total_nxt = total_r;
    if (fire && (act_r == ACT_CLEAR)) begin
      total_nxt = '0;
    end else if (cmd.append) begin
      total_nxt = total_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_COMMIT;
      S_COMMIT: if (fire)   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item hold and incremented count, saturating at the top
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_tdata[1:0];
      key_r     <= in_tdata[33:2];
      found_r   <= found_c[TABLE_DEPTH];
      new_cnt_r <= (hit_cnt == {COUNT_BITS{1'b1}}) ? hit_cnt : hit_cnt + 1'b1;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a committed hit always finds its cell and exactly one insert place
  a_move_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> (passed_c[TABLE_DEPTH] && taken_c[TABLE_DEPTH]))
    else $error("move without a latched hit or insert place");

  a_one_dest: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |-> $onehot(dest_vec))
    else $error("insert place not unique");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule
